// ----- rtl/core/edf_priority_ranker_with_interference_assert.svh -----
// assertion macros for the edf priority ranker
// used by the top level, no other dependencies
`ifndef EDF_PRIORITY_RANKER_WITH_INTERFERENCE_ASSERT_SVH
`define EDF_PRIORITY_RANKER_WITH_INTERFERENCE_ASSERT_SVH
`ifndef SYNTH
`define EDF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("edf ranker check failed");
`define EDF_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("edf ranker check failed");
`else
`define EDF_ASSERT(lbl, clk, rst_n, prop)
`define EDF_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// ----- rtl/core/edf_pkg.sv -----
// shared types, constants and helpers for the edf priority ranker
// no dependencies
package edf_pkg;

    localparam int TASK_SLOTS = 8;
    localparam int SLOT_W     = $clog2(TASK_SLOTS);
    localparam int CNT_W      = $clog2(TASK_SLOTS + 1);

    localparam logic CMD_REGISTER = 1'b0;
    localparam logic CMD_JOB_DONE = 1'b1;

    localparam logic [1:0] CFG_ALPHA     = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_MARGIN    = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_BUILD, S_SORT, S_FIND, S_MUL1, S_MUL2, S_CHECK, S_SWAP, S_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic build;
        logic sort;
        logic find;
        logic mul1;
        logic mul2;
        logic swap;
        logic emit;
        logic clr_i;
        logic start_swap;
    } t_cmd;

    typedef struct packed {
        logic go;
        logic build_last;
        logic sort_done;
        logic find_end;
        logic find_hit;
        logic pen_ok;
        logic swap_end;
        logic swap_hit;
        logic emit_last;
        logic out_free;
    } t_status;

    function automatic logic wrap_pos(input logic [31:0] diff);
        return (diff != 32'd0) && !diff[31];
    endfunction

    // signed distance to deadline minus wcet, exact
    function automatic logic signed [33:0] slack(input logic [31:0] dl,
                                                 input logic [31:0] now,
                                                 input logic [30:0] wcet);
        logic [31:0] d;
        d = dl - now;
        return $signed({{2{d[31]}}, d}) - $signed({3'b000, wcet});
    endfunction

endpackage

// ----- rtl/core/edf_ctrl.sv -----
// reschedule sequencer for the edf priority ranker
// depends on edf_pkg
module edf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  edf_pkg::t_status i_status,
    output edf_pkg::t_cmd    o_cmd
);

    edf_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= edf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            edf_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.go) begin
                        o_cmd.clr_i = 1'b1;
                        n_state     = edf_pkg::S_BUILD;
                    end
                end
            end
            edf_pkg::S_BUILD: begin
                o_cmd.build = 1'b1;
                if (i_status.build_last) begin
                    n_state = edf_pkg::S_SORT;
                end
            end
            edf_pkg::S_SORT: begin
                if (i_status.sort_done) begin
                    o_cmd.clr_i = 1'b1;
                    n_state     = edf_pkg::S_FIND;
                end else begin
                    o_cmd.sort = 1'b1;
                end
            end
            edf_pkg::S_FIND: begin
                if (i_status.find_end) begin
                    o_cmd.clr_i = 1'b1;
                    n_state     = edf_pkg::S_EMIT;
                end else begin
                    o_cmd.find = 1'b1;
                    if (i_status.find_hit) begin
                        n_state = edf_pkg::S_MUL1;
                    end
                end
            end
            edf_pkg::S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = edf_pkg::S_MUL2;
            end
            edf_pkg::S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = edf_pkg::S_CHECK;
            end
            edf_pkg::S_CHECK: begin
                if (i_status.pen_ok) begin
                    o_cmd.start_swap = 1'b1;
                    n_state          = edf_pkg::S_SWAP;
                end else begin
                    o_cmd.clr_i = 1'b1;
                    n_state     = edf_pkg::S_EMIT;
                end
            end
            edf_pkg::S_SWAP: begin
                if (i_status.swap_end) begin
                    o_cmd.clr_i = 1'b1;
                    n_state     = edf_pkg::S_EMIT;
                end else begin
                    o_cmd.swap = 1'b1;
                    if (i_status.swap_hit) begin
                        o_cmd.clr_i = 1'b1;
                        n_state     = edf_pkg::S_EMIT;
                    end
                end
            end
            edf_pkg::S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.emit_last) begin
                        n_state = edf_pkg::S_IDLE;
                    end
                end
            end
            default: n_state = edf_pkg::S_IDLE;
        endcase
    end

endmodule

// ----- rtl/core/edf_datapath.sv -----
// task table, order list, penalty multiplier and output register
// depends on edf_pkg
module edf_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [31:0]                 i_cfg_data,
    input  edf_pkg::t_cmd               i_cmd,
    output edf_pkg::t_status            o_status,
    input  logic                        i_command,
    input  logic [2:0]                  i_task_id,
    input  logic [31:0]                 i_period,
    input  logic [30:0]                 i_wcet,
    input  logic [7:0]                  i_memory_intensity,
    input  logic [31:0]                 i_previous_wake_time,
    input  logic [31:0]                 i_time_increment,
    input  logic [31:0]                 i_current_time,
    input  logic [7:0]                  i_ready_mask,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [2:0]                  o_ranked_task,
    output logic [3:0]                  o_priority_res,
    output logic                        o_deadline_missed,
    output logic                        o_last
);

    localparam int SW = edf_pkg::SLOT_W;
    localparam int CW = edf_pkg::CNT_W;
    localparam int N  = edf_pkg::TASK_SLOTS;

    // configuration
    logic [15:0] r_alpha;
    logic [31:0] r_thr;
    logic [30:0] r_margin;

    // task table
    logic [N-1:0] r_reg;
    logic [31:0]  r_period [N];
    logic [30:0]  r_wcet   [N];
    logic [7:0]   r_inten  [N];
    logic [31:0]  r_dl     [N];
    logic [31:0]  r_wake   [N];
    logic [SW-1:0] r_last_run;

    // order list and its deadlines
    logic [SW-1:0] r_ord [N];
    logic [31:0]   r_odl [N];

    logic [31:0] r_now;
    logic [7:0]  r_mask;
    logic        r_missed;
    logic [CW-1:0] r_cnt, r_i, r_p, r_ci;
    logic [SW-1:0] r_j, r_cslot;
    logic [23:0] r_prod1;
    logic [31:0] r_pen;
    logic [7:0]  r_mc;
    logic signed [33:0] r_cs;

    logic        r_ov;
    logic [2:0]  r_otask;
    logic [3:0]  r_oprio;
    logic        r_omiss, r_olast;

    logic [SW-1:0] w_id;
    logic [31:0]   w_abs_dl;
    logic [SW-1:0] w_cur_slot;
    logic [SW-1:0] w_j1;
    logic          w_swap_dl;
    logic signed [33:0] w_as_slack;
    logic signed [33:0] w_need;
    logic [CW:0]   w_j_end;

    assign w_id       = i_task_id[SW-1:0];
    assign w_abs_dl   = i_previous_wake_time + i_time_increment;
    assign w_cur_slot = r_ord[r_i[SW-1:0]];
    assign w_j1       = r_j + SW'(1);
    assign w_swap_dl  = edf_pkg::wrap_pos(r_odl[r_j] - r_odl[w_j1]);
    assign w_as_slack = edf_pkg::slack(r_dl[w_cur_slot], r_now, r_wcet[w_cur_slot]);
    assign w_need     = $signed({3'b000, r_wcet[w_cur_slot]}) +
                        $signed({3'b000, r_margin});
    assign w_j_end    = (CW+1)'(r_j) + (CW+1)'(2);

    // slot readiness: registered, wake time reached, mask bit set
    logic w_ready;
    always_comb begin
        logic [31:0] since;
        since   = r_now - r_wake[w_cur_slot];
        w_ready = r_reg[w_cur_slot] && !since[31] && r_mask[w_cur_slot];
    end

    always_comb begin
        o_status            = '0;
        o_status.go         = (i_command == edf_pkg::CMD_JOB_DONE) && r_reg[w_id];
        o_status.build_last = (r_i[SW-1:0] == SW'(N - 1));
        o_status.sort_done  = ((CW+1)'(r_p) + (CW+1)'(2)) > (CW+1)'(r_cnt);
        o_status.find_end   = (r_i == r_cnt);
        o_status.find_hit   = w_ready;
        o_status.pen_ok     = (r_pen > r_thr) && (r_cs > $signed({3'b000, r_margin}));
        o_status.swap_end   = (r_i == r_cnt);
        o_status.swap_hit   = w_ready && (r_inten[w_cur_slot] < r_mc) &&
                              (w_as_slack > 34'sd0) && (r_cs > w_need);
        o_status.emit_last  = ((r_i + CW'(1)) == r_cnt);
        o_status.out_free   = !r_ov || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha  <= 16'd256;
            r_thr    <= '0;
            r_margin <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                edf_pkg::CFG_ALPHA:     r_alpha  <= i_cfg_data[15:0];
                edf_pkg::CFG_THRESHOLD: r_thr    <= i_cfg_data;
                edf_pkg::CFG_MARGIN:    r_margin <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // task table and control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg      <= '0;
            r_last_run <= '0;
            r_cnt      <= '0;
            r_i        <= '0;
            r_p        <= '0;
            r_j        <= '0;
            for (int k = 0; k < N; k++) begin
                r_period[k] <= '0;
                r_wcet[k]   <= '0;
                r_inten[k]  <= '0;
                r_dl[k]     <= '0;
                r_wake[k]   <= '0;
            end
        end else begin
            if (i_cmd.accept) begin
                r_now  <= i_current_time;
                r_mask <= i_ready_mask;
                r_cnt  <= '0;
                if (i_command == edf_pkg::CMD_REGISTER) begin
                    r_reg[w_id]    <= 1'b1;
                    r_period[w_id] <= i_period;
                    r_wcet[w_id]   <= i_wcet;
                    r_inten[w_id]  <= i_memory_intensity;
                    r_wake[w_id]   <= i_current_time;
                    r_dl[w_id]     <= i_current_time + i_period;
                end else if (r_reg[w_id]) begin
                    r_missed       <= edf_pkg::wrap_pos(i_current_time - w_abs_dl);
                    r_wake[w_id]   <= w_abs_dl;
                    r_dl[w_id]     <= w_abs_dl + r_period[w_id];
                    r_last_run     <= w_id;
                end
            end
            if (i_cmd.build) begin
                if (r_reg[r_i[SW-1:0]]) begin
                    r_ord[r_cnt[SW-1:0]] <= r_i[SW-1:0];
                    r_odl[r_cnt[SW-1:0]] <= r_dl[r_i[SW-1:0]];
                    r_cnt                <= r_cnt + CW'(1);
                end
                r_i <= r_i + CW'(1);
            end
            if (i_cmd.sort) begin
                if (w_swap_dl) begin
                    r_ord[r_j]  <= r_ord[w_j1];
                    r_ord[w_j1] <= r_ord[r_j];
                    r_odl[r_j]  <= r_odl[w_j1];
                    r_odl[w_j1] <= r_odl[r_j];
                end
                if (w_j_end >= ((CW+1)'(r_cnt) - (CW+1)'(r_p))) begin
                    r_j <= '0;
                    r_p <= r_p + CW'(1);
                end else begin
                    r_j <= w_j1;
                end
            end
            if (i_cmd.find) begin
                if (w_ready) begin
                    r_ci    <= r_i;
                    r_cslot <= w_cur_slot;
                end else begin
                    r_i <= r_i + CW'(1);
                end
            end
            if (i_cmd.start_swap) begin
                r_i <= r_ci + CW'(1);
            end
            if (i_cmd.swap) begin
                // a hit ends the search, the sequencer clears the index
                if (o_status.swap_hit) begin
                    r_ord[r_ci[SW-1:0]] <= w_cur_slot;
                    r_ord[r_i[SW-1:0]]  <= r_cslot;
                end else begin
                    r_i <= r_i + CW'(1);
                end
            end
            if (i_cmd.emit) begin
                r_i <= r_i + CW'(1);
            end
            if (i_cmd.clr_i) begin
                r_i <= '0;
                r_j <= '0;
                r_p <= '0;
            end
        end
    end

    // penalty: alpha * intensity of last run, then times candidate intensity
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_prod1 <= r_alpha * r_inten[r_last_run];
            r_mc    <= r_inten[r_cslot];
            r_cs    <= edf_pkg::slack(r_dl[r_cslot], r_now, r_wcet[r_cslot]);
        end
        if (i_cmd.mul2) begin
            r_pen <= 32'(r_prod1 * r_mc);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_otask <= 3'(w_cur_slot);
            r_oprio <= 4'(r_cnt - r_i);
            r_omiss <= r_missed;
            r_olast <= o_status.emit_last;
        end
    end

    assign o_out_valid       = r_ov;
    assign o_ranked_task     = r_otask;
    assign o_priority_res    = r_oprio;
    assign o_deadline_missed = r_omiss;
    assign o_last            = r_olast;

endmodule

// ----- rtl/core/edf_priority_ranker_with_interference.sv -----
// Earliest-deadline-first priority ranker with a memory-interference swap.
// A register item (command 0) writes one task slot and gives no results.
// A job-done item (command 1) on a registered slot moves that task's wake
// time and deadline forward, then ranks all registered tasks: the eight
// slots are gathered, the tasks are bubble sorted by wrap-aware deadline at
// one compare per cycle, the first ready task is searched at one slot per
// cycle, the interference penalty is formed in the MUL1 and MUL2 states and
// then checked, an optional swap search takes one slot per cycle, and one
// priority item per registered task is then shown, highest first, with
// last set on the final one. The emit step waits while the output register
// is held by the receiver. The input is taken only while the sequencer is
// idle; the final result can still sit in the output register while the
// next item is taken.
// depends on edf_pkg, edf_ctrl, edf_datapath and the assert macro header
`include "edf_priority_ranker_with_interference_assert.svh"
module edf_priority_ranker_with_interference (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    // input item channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [2:0]  i_task_id,
    input  logic [31:0] i_period,
    input  logic [30:0] i_wcet,
    input  logic [7:0]  i_memory_intensity,
    input  logic [31:0] i_previous_wake_time,
    input  logic [31:0] i_time_increment,
    input  logic [31:0] i_current_time,
    input  logic [7:0]  i_ready_mask,
    // result item channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_ranked_task,
    output logic [3:0]  o_priority_res,
    output logic        o_deadline_missed,
    output logic        o_last
);

    edf_pkg::t_cmd    w_cmd;
    edf_pkg::t_status w_status;

    // sequencer: gather, sort, find, penalty, swap, emit
    edf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // task table, order list, multiplier and output register
    edf_datapath u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .i_cmd                (w_cmd),
        .o_status             (w_status),
        .i_command            (i_command),
        .i_task_id            (i_task_id),
        .i_period             (i_period),
        .i_wcet               (i_wcet),
        .i_memory_intensity   (i_memory_intensity),
        .i_previous_wake_time (i_previous_wake_time),
        .i_time_increment     (i_time_increment),
        .i_current_time       (i_current_time),
        .i_ready_mask         (i_ready_mask),
        .i_out_ready          (i_out_ready),
        .o_out_valid          (o_out_valid),
        .o_ranked_task        (o_ranked_task),
        .o_priority_res       (o_priority_res),
        .o_deadline_missed    (o_deadline_missed),
        .o_last               (o_last)
    );

    // the final item of a reschedule always carries priority one
    `EDF_ASSERT(a_last_prio_one, i_clk, i_rst_n, o_out_valid |-> (o_last == (o_priority_res == 4'd1)))
    // no new item is taken while a reschedule still has items to show
    `EDF_ASSERT(a_busy_mid_burst, i_clk, i_rst_n, (o_out_valid && !o_last) |-> !o_in_ready)
    // items of one reschedule follow without a gap once one is taken
    `EDF_ASSERT(a_burst_no_gap, i_clk, i_rst_n, (o_out_valid && i_out_ready && !o_last) |=> o_out_valid)

endmodule
